@@ sv/masked_byte_pattern_scanner_unit_assert.svh @@
// assertion macros for the masked byte pattern scanner checker
// each macro expands to one labeled concurrent assertion, reset gated
`ifndef MASKED_BYTE_PATTERN_SCANNER_UNIT_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SCANNER_UNIT_ASSERT_SVH

// same-cycle implication
`define MSPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("msps same-cycle check failed");

// next-cycle implication
`define MSPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("msps next-cycle check failed");

`endif

@@ sv/msps_pkg.sv @@
// package for the masked byte pattern scanner
// holds sizes, register indexes and payload structs; no dependencies
`timescale 1ns / 1ps

package msps_pkg;

    localparam int MAX_PATTERN_BYTES = 32;
    localparam int LEN_W             = 6;
    localparam int WIN_IDX_W         = 5;
    localparam int ADDR_W            = 32;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_IDX_W         = 3;
    localparam int PAT_REGS          = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_0_7   = 3'd0,
        REG_PAT_8_15  = 3'd1,
        REG_PAT_16_23 = 3'd2,
        REG_PAT_24_31 = 3'd3,
        REG_MASK      = 3'd4,
        REG_LENGTH    = 3'd5,
        REG_BASE_ADDR = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } t_out_item;

endpackage

@@ sv/masked_byte_pattern_scanner_unit.sv @@
// masked byte pattern scanner top level
// depends on msps_pkg; single module with window, compare and result register
`timescale 1ns / 1ps

// Usage:
//   input channel (i_in_valid / o_in_ready / i_in_data) carries one stream byte
//   per transfer, last_byte marking the end of the scanned region.
//   output channel (o_out_valid / i_out_ready / o_out_data) carries at most one
//   result per scan: found=1 with base plus match offset at the first match,
//   or found=0 with address 0 when the last byte passes without a match.
//   bytes after a match give no result until the last byte ends the scan.
// Timing:
//   one byte accepted every cycle unless a held result stalls input; a result
//   is registered in the cycle after its byte is accepted. the 32-entry shift
//   window and the parallel masked compare check each byte combinationally.
// Stall:
//   a held result blocks input only when it is not taken in the same cycle;
//   o_in_ready = output register empty or being taken.
// Reset:
//   synchronous active low; config returns to zero with length 1, the scan
//   restarts, output register empties. the user must write config (i_cfg_we /
//   i_cfg_index / i_cfg_data) while no scan result is pending; not enforced.
module masked_byte_pattern_scanner_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  msps_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output msps_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [msps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [msps_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [msps_pkg::PAT_REGS-1:0][msps_pkg::CFG_DATA_W-1:0] r_pat;
    logic [msps_pkg::MAX_PATTERN_BYTES-1:0]                  r_mask;
    logic [msps_pkg::LEN_W-1:0]                              r_len;
    logic [msps_pkg::ADDR_W-1:0]                             r_base;

    logic [msps_pkg::MAX_PATTERN_BYTES-1:0][7:0] r_win;
    logic [msps_pkg::MAX_PATTERN_BYTES-1:0][7:0] n_win;
    logic [msps_pkg::ADDR_W-1:0]                 r_seen;
    logic [msps_pkg::ADDR_W-1:0]                 n_seen;
    logic                                        r_done;

    logic                 r_out_valid;
    msps_pkg::t_out_item  r_out_data;

    logic [msps_pkg::MAX_PATTERN_BYTES-1:0][7:0] w_pat;
    logic [msps_pkg::LEN_W-1:0]                  w_len;
    logic                                        w_cmp_ok;
    logic                                        w_hit;
    logic                                        w_emit;
    logic                                        w_fire;
    logic [msps_pkg::ADDR_W-1:0]                 w_start;
    logic [msps_pkg::WIN_IDX_W-1:0]              v_idx;

    assign w_pat  = r_pat;
    assign w_fire = i_in_valid && o_in_ready;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // effective length clamped to 1..32
    always_comb begin
        if (r_len == '0) begin
            w_len = msps_pkg::LEN_W'(1);
        end else if (r_len > msps_pkg::LEN_W'(msps_pkg::MAX_PATTERN_BYTES)) begin
            w_len = msps_pkg::LEN_W'(msps_pkg::MAX_PATTERN_BYTES);
        end else begin
            w_len = r_len;
        end
    end

    assign n_win  = {r_win[msps_pkg::MAX_PATTERN_BYTES-2:0], i_in_data.data_byte};
    assign n_seen = (&r_seen) ? r_seen : r_seen + msps_pkg::ADDR_W'(1);

    // pattern byte i against the window entry len-1-i bytes old
    always_comb begin
        v_idx    = '0;
        w_cmp_ok = 1'b1;
        for (int i = 0; i < msps_pkg::MAX_PATTERN_BYTES; i++) begin
            v_idx = msps_pkg::WIN_IDX_W'(w_len - msps_pkg::LEN_W'(1) - msps_pkg::LEN_W'(i));
            if ((msps_pkg::LEN_W'(i) < w_len) && r_mask[i] && (n_win[v_idx] != w_pat[i])) begin
                w_cmp_ok = 1'b0;
            end
        end
    end

    assign w_hit   = !r_done && (n_seen >= msps_pkg::ADDR_W'(w_len)) && w_cmp_ok;
    assign w_emit  = w_hit || (i_in_data.last_byte && !r_done);
    assign w_start = n_seen - msps_pkg::ADDR_W'(w_len);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_mask <= '0;
            r_len  <= msps_pkg::LEN_W'(1);
            r_base <= '0;
        end else if (i_cfg_we) begin
            unique case (msps_pkg::t_cfg_reg'(i_cfg_index))
                msps_pkg::REG_PAT_0_7:   r_pat[0] <= i_cfg_data;
                msps_pkg::REG_PAT_8_15:  r_pat[1] <= i_cfg_data;
                msps_pkg::REG_PAT_16_23: r_pat[2] <= i_cfg_data;
                msps_pkg::REG_PAT_24_31: r_pat[3] <= i_cfg_data;
                msps_pkg::REG_MASK:      r_mask   <= i_cfg_data[msps_pkg::MAX_PATTERN_BYTES-1:0];
                msps_pkg::REG_LENGTH:    r_len    <= i_cfg_data[msps_pkg::LEN_W-1:0];
                msps_pkg::REG_BASE_ADDR: r_base   <= i_cfg_data[msps_pkg::ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // window contents only matter once the seen-byte count covers the pattern
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_win <= n_win;
        end
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_done <= 1'b0;
        end else if (w_fire) begin
            if (i_in_data.last_byte) begin
                r_seen <= '0;
                r_done <= 1'b0;
            end else begin
                r_seen <= n_seen;
                r_done <= r_done || w_hit;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= w_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_out_data.found         <= w_hit;
            r_out_data.match_address <= w_hit ? (r_base + w_start) : '0;
        end
    end

endmodule

@@ sv/msps_checker.sv @@
// port-level checker for the masked byte pattern scanner
// depends on msps_pkg and masked_byte_pattern_scanner_unit_assert.svh; bound to the top level
`timescale 1ns / 1ps
`include "masked_byte_pattern_scanner_unit_assert.svh"

module msps_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_ready,
    input  msps_pkg::t_in_item                  i_in_data,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  msps_pkg::t_out_item                 o_out_data
);

    logic w_in_wait;
    logic w_out_wait;
    logic w_miss;

    assign w_in_wait  = i_in_valid && !o_in_ready;
    assign w_out_wait = o_out_valid && !i_out_ready;
    assign w_miss     = o_out_valid && !o_out_data.found;

    `MSPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_wait, o_out_valid)
    `MSPS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, w_out_wait, $stable(o_out_data))
    `MSPS_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, w_in_wait, i_in_valid && $stable(i_in_data))
    `MSPS_ASSERT_SAME(a_miss_zero, i_clk, i_rst_n, w_miss, o_out_data.match_address == '0)
    `MSPS_ASSERT_SAME(a_ready_empty, i_clk, i_rst_n, !o_out_valid || i_out_ready, o_in_ready)

endmodule

bind masked_byte_pattern_scanner_unit msps_checker u_msps_checker (.*);
